[rtl/mpol_pkg.sv]
`timescale 1ns / 1ps
package mpol_pkg;

	// tracker modes
	localparam logic [1:0] MODE_SCAN  = 2'd0;
	localparam logic [1:0] MODE_TRACK = 2'd1;
	localparam logic [1:0] MODE_LOCK  = 2'd2;

	// input actions
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_RESCAN = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_START  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STEP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCK_THRESH = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCK_LIMIT  = 3'd7;

	// power-on value of the sweep duty and of the applied duty
	localparam logic [6:0] RESET_DUTY = 7'd10;

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [6:0]  scan_start_duty;
		logic [5:0]  scan_step;
		logic [6:0]  duty_min;
		logic [6:0]  duty_max;
		logic [4:0]  duty_step;
		logic [23:0] perturb_deadband;
		logic [23:0] lock_power_threshold;
		logic [7:0]  lock_count_limit;
	} cfg_t;

	// one classified word handed from front to back
	typedef struct packed {
		logic        action;
		logic [31:0] power;
		logic        over_band;
		logic        stable;
		logic        not_rise;
	} entry_t;

endpackage

[rtl/mppt_perturb_observe_scan_lock.sv]
`timescale 1ns / 1ps
// A word passes through the front multiply stage, the queue and the back output registers in turn.
// Throughput: one word per cycle while neither input nor output stalls; the back's state update is combinational.
// The front multiply stage and a four-entry queue let input and output stall independently.
// Reset (async, active low) restores the register defaults, scanning mode at duty 10,
// and empties the pipeline and queue; no clearing pass is needed.
module mppt_perturb_observe_scan_lock #(
	parameter int PWM_PERIOD_COUNTS = 8400
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [15:0] pv_voltage,
	input  logic [15:0] pv_current,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  duty_percent,
	output logic [13:0] pwm_compare,
	output logic [1:0]  tracker_mode,
	output logic [31:0] measured_power,
	output logic [31:0] best_power,
	input  logic        cfg_we,
	input  logic [mpol_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mpol_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mpol_pkg::*;

	cfg_t   cfg_q;
	logic   push;
	entry_t push_entry;
	logic   pop;
	logic   q_full;
	logic   q_valid;
	entry_t q_head;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_start_duty      <= 7'd10;
			cfg_q.scan_step            <= 6'd5;
			cfg_q.duty_min             <= 7'd5;
			cfg_q.duty_max             <= 7'd90;
			cfg_q.duty_step            <= 5'd1;
			cfg_q.perturb_deadband     <= 24'd10000;
			cfg_q.lock_power_threshold <= 24'd100000;
			cfg_q.lock_count_limit     <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCAN_START:  cfg_q.scan_start_duty      <= cfg_data[6:0];
				CFG_SCAN_STEP:   cfg_q.scan_step            <= cfg_data[5:0];
				CFG_DUTY_MIN:    cfg_q.duty_min             <= cfg_data[6:0];
				CFG_DUTY_MAX:    cfg_q.duty_max             <= cfg_data[6:0];
				CFG_DUTY_STEP:   cfg_q.duty_step            <= cfg_data[4:0];
				CFG_DEADBAND:    cfg_q.perturb_deadband     <= cfg_data;
				CFG_LOCK_THRESH: cfg_q.lock_power_threshold <= cfg_data;
				CFG_LOCK_LIMIT:  cfg_q.lock_count_limit     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	mpol_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.pv_voltage (pv_voltage),
		.pv_current (pv_current),
		.cfg        (cfg_q),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	mpol_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.q_full     (q_full),
		.q_valid    (q_valid),
		.q_head     (q_head)
	);

	mpol_back #(
		.PWM_PERIOD_COUNTS (PWM_PERIOD_COUNTS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.duty_percent   (duty_percent),
		.pwm_compare    (pwm_compare),
		.tracker_mode   (tracker_mode),
		.measured_power (measured_power),
		.best_power     (best_power)
	);

	// front stalls only on a full queue
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full)
		else $error("input stalled while queue has room");

	// a popped rescan word reports scanning with cleared best power
	a_rescan_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_head.action == ACT_RESCAN |=>
		out_valid && tracker_mode == MODE_SCAN && best_power == 32'd0)
		else $error("rescan word did not restart the sweep");

	// no reserved mode code reaches the output
	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tracker_mode != 2'd3)
		else $error("reserved tracker mode on output");

	// queue never pops empty
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

endmodule

[rtl/mpol_front.sv]
`timescale 1ns / 1ps
module mpol_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            action,
	input  logic [15:0]     pv_voltage,
	input  logic [15:0]     pv_current,
	input  mpol_pkg::cfg_t  cfg,
	input  logic            q_full,
	output logic            push,
	output mpol_pkg::entry_t push_entry
);
	import mpol_pkg::*;

	logic        valid_s1;
	logic        action_s1;
	logic [31:0] power_s1;
	logic [31:0] last_power_q;
	logic [31:0] delta;

	// hold the stage while the queue is full
	assign in_stall = valid_s1 && q_full;
	assign push     = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			last_power_q <= '0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (push && action_s1 == ACT_SAMPLE)
				last_power_q <= power_s1;
		end
	end

	// form power in microwatts
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			action_s1 <= action;
			power_s1  <= {16'd0, pv_voltage} * {16'd0, pv_current};
		end
	end

	// classify the change against the previous sample
	always_comb begin
		if (power_s1 >= last_power_q)
			delta = power_s1 - last_power_q;
		else
			delta = last_power_q - power_s1;
		push_entry.action    = action_s1;
		push_entry.power     = power_s1;
		push_entry.over_band = delta > {8'd0, cfg.perturb_deadband};
		push_entry.stable    = delta < {8'd0, cfg.lock_power_threshold};
		push_entry.not_rise  = power_s1 <= last_power_q;
	end

endmodule

[rtl/mpol_queue.sv]
`timescale 1ns / 1ps
module mpol_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mpol_pkg::entry_t push_entry,
	input  logic             pop,
	output logic             q_full,
	output logic             q_valid,
	output mpol_pkg::entry_t q_head
);
	import mpol_pkg::*;

	entry_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign q_full  = count_q == (Q_PTR_W+1)'(Q_DEPTH);
	assign q_valid = count_q != '0;
	assign q_head  = mem_q[rd_ptr_q];

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

[rtl/mpol_back.sv]
`timescale 1ns / 1ps
module mpol_back #(
	parameter int PWM_PERIOD_COUNTS = 8400
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mpol_pkg::cfg_t   cfg,
	input  logic             q_valid,
	input  mpol_pkg::entry_t q_head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [6:0]       duty_percent,
	output logic [13:0]      pwm_compare,
	output logic [1:0]       tracker_mode,
	output logic [31:0]      measured_power,
	output logic [31:0]      best_power
);
	import mpol_pkg::*;

	typedef logic [127:0][13:0] pwm_lut_t;

	function automatic pwm_lut_t build_lut();
		pwm_lut_t   lut;
		longint     prod;
		for (int i = 0; i < 128; i++) begin
			prod   = longint'(i) * longint'(PWM_PERIOD_COUNTS);
			lut[i] = 14'(prod / 100);
		end
		return lut;
	endfunction

	localparam pwm_lut_t PWM_LUT = build_lut();

	function automatic logic [6:0] clamp(logic [7:0] d, logic [6:0] lo, logic [6:0] hi);
		if (d < {1'b0, lo})
			return lo;
		else if (d > {1'b0, hi})
			return hi;
		return d[6:0];
	endfunction

	logic [1:0]  mode_q, mode_n;
	logic [7:0]  sweep_q, sweep_n;
	logic [6:0]  applied_q, applied_n;
	logic        down_q, down_n;
	logic [31:0] peak_power_q, peak_power_n;
	logic [7:0]  peak_duty_q, peak_duty_n;
	logic [7:0]  stable_cnt_q, stable_cnt_n;
	logic [31:0] power_q, power_n;
	logic        out_valid_q;
	logic [6:0]  out_duty_q;
	logic [1:0]  out_mode_q;
	logic [31:0] out_power_q;
	logic [31:0] out_best_q;
	logic signed [8:0] nxt;
	logic [7:0]  nxt_clamped;
	logic [7:0]  cnt_inc;

	assign pop = q_valid && (!out_valid_q || !out_stall);

	// next state for one word
	always_comb begin
		mode_n       = mode_q;
		sweep_n      = sweep_q;
		applied_n    = applied_q;
		down_n       = down_q;
		peak_power_n = peak_power_q;
		peak_duty_n  = peak_duty_q;
		stable_cnt_n = stable_cnt_q;
		power_n      = power_q;
		nxt          = '0;
		nxt_clamped  = '0;
		cnt_inc      = (stable_cnt_q == 8'hFF) ? stable_cnt_q : stable_cnt_q + 8'd1;
		if (q_head.action == ACT_RESCAN) begin
			mode_n       = MODE_SCAN;
			sweep_n      = {1'b0, cfg.scan_start_duty};
			peak_power_n = '0;
			peak_duty_n  = {1'b0, cfg.scan_start_duty};
			stable_cnt_n = '0;
		end else begin
			power_n = q_head.power;
			case (mode_q)
				MODE_SCAN: begin
					if (q_head.power > peak_power_q) begin
						peak_power_n = q_head.power;
						peak_duty_n  = sweep_q;
					end
					sweep_n = sweep_q + {2'b0, cfg.scan_step};
					if (sweep_n > {1'b0, cfg.duty_max}) begin
						mode_n    = MODE_TRACK;
						down_n    = 1'b0;
						applied_n = clamp(peak_duty_n, cfg.duty_min, cfg.duty_max);
					end else begin
						applied_n = clamp(sweep_n, cfg.duty_min, cfg.duty_max);
					end
				end
				MODE_TRACK: begin
					// perturb outside the dead band, bounce at the limits
					if (q_head.over_band) begin
						down_n = down_q ^ q_head.not_rise;
						if (down_n)
							nxt = $signed({2'b0, applied_q}) - $signed({4'b0, cfg.duty_step});
						else
							nxt = $signed({2'b0, applied_q}) + $signed({4'b0, cfg.duty_step});
						if (nxt < $signed({2'b0, cfg.duty_min})) begin
							nxt_clamped = {1'b0, cfg.duty_min};
							down_n      = 1'b0;
						end else if (nxt > $signed({2'b0, cfg.duty_max})) begin
							nxt_clamped = {1'b0, cfg.duty_max};
							down_n      = 1'b1;
						end else begin
							nxt_clamped = nxt[7:0];
						end
						applied_n = clamp(nxt_clamped, cfg.duty_min, cfg.duty_max);
					end
					// count stable samples toward lock
					if (q_head.stable) begin
						stable_cnt_n = cnt_inc;
						if (cnt_inc >= cfg.lock_count_limit)
							mode_n = MODE_LOCK;
					end else begin
						stable_cnt_n = '0;
					end
				end
				MODE_LOCK: begin
					if (!q_head.stable) begin
						mode_n       = MODE_TRACK;
						stable_cnt_n = '0;
					end
				end
				default: begin
					mode_n = MODE_SCAN;
				end
			endcase
		end
	end

	// commit state and load the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_SCAN;
			sweep_q      <= {1'b0, RESET_DUTY};
			applied_q    <= RESET_DUTY;
			down_q       <= 1'b0;
			peak_power_q <= '0;
			peak_duty_q  <= '0;
			stable_cnt_q <= '0;
			power_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				mode_q       <= mode_n;
				sweep_q      <= sweep_n;
				applied_q    <= applied_n;
				down_q       <= down_n;
				peak_power_q <= peak_power_n;
				peak_duty_q  <= peak_duty_n;
				stable_cnt_q <= stable_cnt_n;
				power_q      <= power_n;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_duty_q  <= applied_n;
			out_mode_q  <= (mode_n > MODE_LOCK) ? MODE_SCAN : mode_n;
			out_power_q <= power_n;
			out_best_q  <= peak_power_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign duty_percent   = out_duty_q;
	assign pwm_compare    = PWM_LUT[out_duty_q];
	assign tracker_mode   = out_mode_q;
	assign measured_power = out_power_q;
	assign best_power     = out_best_q;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
	import mpol_pkg::*;

	localparam int PWM_COUNTS  = 8400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 80;
	localparam int PHASES      = 8;

	typedef struct packed {
		logic [6:0]  duty_percent;
		logic [13:0] pwm_compare;
		logic [1:0]  tracker_mode;
		logic [31:0] measured_power;
		logic [31:0] best_power;
	} status_t;

	typedef struct {
		cfg_t regs;
		int   slope;
		int   ripple_v;
		int   ripple_i;
		int   junk_pct;
		int   words;
	} phase_t;

	// Tracker state mirror: predicts the status word for every accepted word
	class mppt_board;
		cfg_t        regs;
		logic [1:0]  mode;
		logic [7:0]  sweep_duty;
		logic [6:0]  duty;
		logic        going_down;
		logic [31:0] peak_power;
		logic [7:0]  peak_duty;
		logic [7:0]  stable_run;
		logic [31:0] power_now;
		logic [31:0] power_last;
		status_t     status_due[$];
		int          words_noted;
		int          errors;

		function new();
			regs.scan_start_duty      = RESET_DUTY;
			regs.scan_step            = 6'd5;
			regs.duty_min             = 7'd5;
			regs.duty_max             = 7'd90;
			regs.duty_step            = 5'd1;
			regs.perturb_deadband     = 24'd10000;
			regs.lock_power_threshold = 24'd100000;
			regs.lock_count_limit     = 8'd10;
			mode        = MODE_SCAN;
			sweep_duty  = 8'(RESET_DUTY);
			duty        = RESET_DUTY;
			going_down  = 1'b0;
			peak_power  = '0;
			peak_duty   = '0;
			stable_run  = '0;
			power_now   = '0;
			power_last  = '0;
			words_noted = 0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_SCAN_START:  regs.scan_start_duty      = data[6:0];
				CFG_SCAN_STEP:   regs.scan_step            = data[5:0];
				CFG_DUTY_MIN:    regs.duty_min             = data[6:0];
				CFG_DUTY_MAX:    regs.duty_max             = data[6:0];
				CFG_DUTY_STEP:   regs.duty_step            = data[4:0];
				CFG_DEADBAND:    regs.perturb_deadband     = data;
				CFG_LOCK_THRESH: regs.lock_power_threshold = data;
				CFG_LOCK_LIMIT:  regs.lock_count_limit     = data[7:0];
				default: ;
			endcase
		endfunction

		// Clamp to the duty window; in an inverted window a value below the low bound takes it, any other the high bound
		function void clamp_to(int d);
			if (d < int'(regs.duty_min))
				d = int'(regs.duty_min);
			else if (d > int'(regs.duty_max))
				d = int'(regs.duty_max);
			duty = d[6:0];
		endfunction

		function void note_sample(logic act, logic [15:0] volts, logic [15:0] amps);
			logic [31:0] swing;
			logic        calm;
			int          step_to;
			status_t     st;
			words_noted++;
			if (act == ACT_RESCAN) begin
				// restart the sweep; duty and power readings stay
				mode       = MODE_SCAN;
				sweep_duty = 8'(regs.scan_start_duty);
				peak_power = '0;
				peak_duty  = 8'(regs.scan_start_duty);
				stable_run = '0;
			end else begin
				power_last = power_now;
				power_now  = 32'(volts) * 32'(amps);
				swing = (power_now >= power_last) ? power_now - power_last
				                                  : power_last - power_now;
				calm  = swing < {8'h00, regs.lock_power_threshold};
				case (mode)
					MODE_SCAN: begin
						if (power_now > peak_power) begin
							peak_power = power_now;
							peak_duty  = sweep_duty;
						end
						sweep_duty = 8'(sweep_duty + regs.scan_step);
						if (sweep_duty > regs.duty_max) begin
							mode       = MODE_TRACK;
							going_down = 1'b0;
							clamp_to(int'(peak_duty));
						end else begin
							clamp_to(int'(sweep_duty));
						end
					end
					MODE_TRACK: begin
						// perturb only outside the dead band; bounce at the limits
						if (swing > {8'h00, regs.perturb_deadband}) begin
							if (power_now <= power_last)
								going_down = !going_down;
							step_to = going_down ? int'(duty) - int'(regs.duty_step)
							                     : int'(duty) + int'(regs.duty_step);
							if (step_to < int'(regs.duty_min)) begin
								step_to    = int'(regs.duty_min);
								going_down = 1'b0;
							end else if (step_to > int'(regs.duty_max)) begin
								step_to    = int'(regs.duty_max);
								going_down = 1'b1;
							end
							clamp_to(step_to);
						end
						if (calm) begin
							if (stable_run != 8'hFF)
								stable_run++;
							if (stable_run >= regs.lock_count_limit)
								mode = MODE_LOCK;
						end else begin
							stable_run = '0;
						end
					end
					MODE_LOCK: begin
						if (!calm) begin
							mode       = MODE_TRACK;
							stable_run = '0;
						end
					end
					default: mode = MODE_SCAN;
				endcase
			end
			st.duty_percent   = duty;
			st.pwm_compare    = 14'((int'(duty) * PWM_COUNTS) / 100);
			st.tracker_mode   = (mode > MODE_LOCK) ? MODE_SCAN : mode;
			st.measured_power = power_now;
			st.best_power     = peak_power;
			status_due.push_back(st);
		endfunction

		function void check_status(status_t got);
			status_t want;
			if (status_due.size() == 0) begin
				$error("status word with none due: duty %0d mode %0d power %0d",
				       got.duty_percent, got.tracker_mode, got.measured_power);
				errors++;
				return;
			end
			want = status_due.pop_front();
			if (got.duty_percent !== want.duty_percent) begin
				$error("duty_percent: expected %0d, got %0d", want.duty_percent, got.duty_percent);
				errors++;
			end
			if (got.pwm_compare !== want.pwm_compare) begin
				$error("pwm_compare: expected %0d, got %0d", want.pwm_compare, got.pwm_compare);
				errors++;
			end
			if (got.tracker_mode !== want.tracker_mode) begin
				$error("tracker_mode: expected %0d, got %0d", want.tracker_mode, got.tracker_mode);
				errors++;
			end
			if (got.measured_power !== want.measured_power) begin
				$error("measured_power: expected %0d, got %0d",
				       want.measured_power, got.measured_power);
				errors++;
			end
			if (got.best_power !== want.best_power) begin
				$error("best_power: expected %0d, got %0d", want.best_power, got.best_power);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  action;
	logic [15:0]           pv_voltage;
	logic [15:0]           pv_current;
	logic                  out_valid;
	logic                  out_stall;
	logic [6:0]            duty_percent;
	logic [13:0]           pwm_compare;
	logic [1:0]            tracker_mode;
	logic [31:0]           measured_power;
	logic [31:0]           best_power;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mppt_board board;
	int        burst_left;
	int        cycles = 0;
	int        peak_at, slope, ripple_v, ripple_i, base_i, junk_pct;

	mppt_perturb_observe_scan_lock #(
		.PWM_PERIOD_COUNTS(PWM_COUNTS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.pv_voltage    (pv_voltage),
		.pv_current    (pv_current),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.duty_percent  (duty_percent),
		.pwm_compare   (pwm_compare),
		.tracker_mode  (tracker_mode),
		.measured_power(measured_power),
		.best_power    (best_power),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Check every status word taken by the receiver
	always @(posedge clk) begin
		status_t got;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			got.duty_percent   = duty_percent;
			got.pwm_compare    = pwm_compare;
			got.tracker_mode   = tracker_mode;
			got.measured_power = measured_power;
			got.best_power     = best_power;
			board.check_status(got);
		end
	end

	// Receiver: free-flowing, random and periodic stall stretches, plus two long hold-offs
	initial begin
		int seg_len;
		int seg_kind;
		int holds_done;
		holds_done = 0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			seg_kind = $urandom_range(0, 2);
			seg_len  = $urandom_range(5, 60);
			for (int k = 0; k < seg_len; k++) begin
				if (holds_done < 2 && board.words_noted >= (holds_done + 1) * 300) begin
					out_stall <= 1'b1;
					repeat (LONG_HOLD) @(posedge clk);
					holds_done++;
				end
				case (seg_kind)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 99) < 40);
					default: out_stall <= (k % 4 == 3);
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic cfg_t make_cfg(int start, int stride, int lo, int hi, int dstep,
	                                  int band, int thresh, int limit);
		cfg_t r;
		r.scan_start_duty      = start[6:0];
		r.scan_step            = stride[5:0];
		r.duty_min             = lo[6:0];
		r.duty_max             = hi[6:0];
		r.duty_step            = dstep[4:0];
		r.perturb_deadband     = band[23:0];
		r.lock_power_threshold = thresh[23:0];
		r.lock_count_limit     = limit[7:0];
		return r;
	endfunction

	// Offer one word, hold it until taken, then pace the next one in bursts
	task automatic send_word(input logic act, input logic [15:0] volts,
	                         input logic [15:0] amps);
		int gap;
		in_valid   <= 1'b1;
		action     <= act;
		pv_voltage <= volts;
		pv_current <= amps;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.note_sample(act, volts, amps);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 24);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.status_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		phase_t                plan[PHASES];
		logic [CFG_DATA_W-1:0] vals[8];
		int                    n, lo, hi, tmp, span, volts, amps;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		action     <= ACT_SAMPLE;
		pv_voltage <= '0;
		pv_current <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_SCAN_START;
		cfg_data   <= '0;
		board      = new();
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero-power sweep: best duty is never recorded, so tracking opens at duty_min
		send_word(ACT_SAMPLE, 16'h0000, 16'h0000);
		send_word(ACT_SAMPLE, 16'h0000, 16'hFFFF);
		send_word(ACT_SAMPLE, 16'hFFFF, 16'h0000);
		for (n = 0; n < 14; n++)
			send_word(ACT_SAMPLE, 16'h0000, 16'($urandom));
		// Tracking: full-scale rise, hold, fall, small step
		send_word(ACT_SAMPLE, 16'hFFFF, 16'hFFFF);
		send_word(ACT_SAMPLE, 16'hFFFF, 16'hFFFF);
		send_word(ACT_SAMPLE, 16'h0000, 16'h0000);
		send_word(ACT_SAMPLE, 16'h0001, 16'h0001);
		// Forced rescan ignores its readings; then sweep with a full-scale peak
		send_word(ACT_RESCAN, 16'hFFFF, 16'hFFFF);
		send_word(ACT_SAMPLE, 16'hFFFF, 16'hFFFF);
		send_word(ACT_SAMPLE, 16'h5555, 16'hAAAA);

		// Low extremes: slowest sweep over the full window, no dead band, never stable
		plan[0].regs = make_cfg(0, 1, 0, 100, 1, 0, 0, 1);
		plan[0].slope = 150; plan[0].ripple_v = 20; plan[0].ripple_i = 2;
		plan[0].junk_pct = 5; plan[0].words = 140;
		// High extremes: one-sample sweep, widest bands, flat power to reach a 255 lock count
		plan[1].regs = make_cfg(100, 50, 0, 100, 20, 16777215, 16777215, 255);
		plan[1].slope = 100; plan[1].ripple_v = 0; plan[1].ripple_i = 0;
		plan[1].junk_pct = 0; plan[1].words = 300;
		// Inverted window and a zero lock limit
		plan[2].regs = make_cfg(30, 7, 60, 40, 3, 5000, 200000, 0);
		plan[2].slope = 200; plan[2].ripple_v = 10; plan[2].ripple_i = 1;
		plan[2].junk_pct = 10; plan[2].words = 90;
		for (int p = 3; p < PHASES; p++) begin
			lo = $urandom_range(0, 100);
			hi = $urandom_range(0, 100);
			if (lo > hi && $urandom_range(0, 3) != 0) begin
				tmp = lo;
				lo  = hi;
				hi  = tmp;
			end
			plan[p].regs = make_cfg($urandom_range(0, 100), $urandom_range(1, 50), lo, hi,
				$urandom_range(1, 20),
				$urandom_range(0, 1) ? $urandom_range(0, 300000) : $urandom_range(0, 16777215),
				$urandom_range(0, 1) ? $urandom_range(0, 300000) : $urandom_range(0, 16777215),
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 20));
			plan[p].slope    = $urandom_range(20, 400);
			plan[p].ripple_v = $urandom_range(0, 50);
			plan[p].ripple_i = $urandom_range(0, 5);
			plan[p].junk_pct = $urandom_range(5, 25);
			plan[p].words    = 85;
		end

		for (int p = 0; p < PHASES; p++) begin
			// Reprogram only with nothing in flight
			drain();
			vals[CFG_SCAN_START]  = CFG_DATA_W'(plan[p].regs.scan_start_duty);
			vals[CFG_SCAN_STEP]   = CFG_DATA_W'(plan[p].regs.scan_step);
			vals[CFG_DUTY_MIN]    = CFG_DATA_W'(plan[p].regs.duty_min);
			vals[CFG_DUTY_MAX]    = CFG_DATA_W'(plan[p].regs.duty_max);
			vals[CFG_DUTY_STEP]   = CFG_DATA_W'(plan[p].regs.duty_step);
			vals[CFG_DEADBAND]    = plan[p].regs.perturb_deadband;
			vals[CFG_LOCK_THRESH] = plan[p].regs.lock_power_threshold;
			vals[CFG_LOCK_LIMIT]  = CFG_DATA_W'(plan[p].regs.lock_count_limit);
			for (int k = 0; k < (1 << CFG_IDX_W); k++) begin
				cfg_we    <= 1'b1;
				cfg_index <= k[CFG_IDX_W-1:0];
				cfg_data  <= vals[k];
				@(posedge clk);
				board.write_reg(k[CFG_IDX_W-1:0], vals[k]);
			end
			cfg_we <= 1'b0;

			slope    = plan[p].slope;
			ripple_v = plan[p].ripple_v;
			ripple_i = plan[p].ripple_i;
			junk_pct = plan[p].junk_pct;
			peak_at  = $urandom_range(plan[p].regs.duty_min, plan[p].regs.duty_max);
			base_i   = $urandom_range(500, 2000);

			// Open each phase with a fresh sweep under the new settings
			send_word(ACT_RESCAN, 16'($urandom), 16'($urandom));
			for (n = 0; n < plan[p].words; n++) begin
				if ($urandom_range(0, 99) < junk_pct) begin
					case ($urandom_range(0, 3))
						0: send_word(ACT_RESCAN, 16'($urandom), 16'($urandom));
						1: send_word(ACT_SAMPLE, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
						             $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
						default: send_word(ACT_SAMPLE, 16'($urandom), 16'($urandom));
					endcase
				end else begin
					// Panel curve: power peaks at peak_at, which moves now and then
					if (junk_pct > 0 && $urandom_range(0, 99) < 3)
						peak_at = $urandom_range(0, 100);
					span = int'(board.duty) - peak_at;
					if (span < 0)
						span = -span;
					volts = 50000 - slope * span + $urandom_range(0, ripple_v);
					if (volts < 0)
						volts = 0;
					else if (volts > 65535)
						volts = 65535;
					amps = base_i + $urandom_range(0, ripple_i);
					send_word(ACT_SAMPLE, volts[15:0], amps[15:0]);
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.status_due.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule

[filelist.f]
rtl/mpol_pkg.sv
rtl/mpol_front.sv
rtl/mpol_queue.sv
rtl/mpol_back.sv
rtl/mppt_perturb_observe_scan_lock.sv
bench/tb.sv
